// ----- rtl/core/pelog_pkg.sv -----
// Shared types and constants for the protected event ring log.
package pelog_pkg;

  typedef enum logic [1:0] {
    CMD_INIT  = 2'd0,
    CMD_LOG   = 2'd1,
    CMD_READ  = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_ACK = 2'd0,
    KIND_REC = 2'd1,
    KIND_END = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    STAT_DONE    = 2'd0,
    STAT_DROPPED = 2'd1,
    STAT_IGNORED = 2'd2
  } status_e;

  localparam logic [1:0] CLS_CRITICAL = 2'd0;
  localparam logic [1:0] CLS_INFO     = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOG_CHK,
    S_RD_ISSUE,
    S_RD_CHECK,
    S_RD_END,
    S_CLR_ISSUE,
    S_CLR_CHECK
  } state_e;

  // One classified command word, as it travels from front to back.
  typedef struct packed {
    cmd_e        cmd;
    logic [15:0] id;
    logic [1:0]  cls;
    logic [63:0] payload;
    logic [5:0]  limit;
    logic [31:0] now;
  } op_t;

  // One ring slot as held in memory, valid flag included.
  typedef struct packed {
    logic        vld;
    logic [1:0]  cls;
    logic [15:0] id;
    logic [31:0] ts;
    logic [63:0] payload;
  } slot_t;

  // Queue status toward the back end.
  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

endpackage

// ----- rtl/core/protected_event_ring_log_core.sv -----
// Top level of the protected event ring log: front end, command queue and back end.
//
// A command word is taken when start is high and busy is low; busy rises only
// while the two-entry command queue is full. Results come out on out_valid_o
// for a single cycle each and cannot be held off, so the receiver must take
// every one. In the back end, init, logs into a ring with room and ignored
// commands finish in the cycle that dispatches them; a log into a full ring
// first reads the oldest slot from the ring memory, then decides and writes.
// A read visits slots newest first, each with a memory read and then a check,
// and closes with an end marker. Clear-info sweeps every slot through the
// single memory read port. The valid flag of each slot lives in the ring
// memory; the fill count bounds every lookup to slots written since the last
// init, so neither reset nor init needs a clearing pass. The boot identifier
// register may be written only while no command is pending.
module protected_event_ring_log_core #(
  parameter int RING_DEPTH    = 256,
  parameter int PAYLOAD_BYTES = 8,
  parameter int MAX_READ      = 63
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  command_i,
  input  logic [15:0] event_id_i,
  input  logic [1:0]  event_class_i,
  input  logic [63:0] payload_i,
  input  logic [7:0]  payload_length_i,
  input  logic [5:0]  read_limit_i,
  input  logic [31:0] time_now_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i,
  output logic        out_valid_o,
  output logic [1:0]  kind_o,
  output logic [1:0]  status_o,
  output logic [31:0] rec_timestamp_o,
  output logic [15:0] rec_event_id_o,
  output logic [1:0]  rec_class_o,
  output logic [7:0]  rec_subsystem_o,
  output logic [63:0] rec_payload_o,
  output logic [5:0]  records_returned_o,
  output logic        last_o
);

  logic [15:0]        boot_q;
  pelog_pkg::op_t     front_op, head_op;
  pelog_pkg::q_stat_t q_stat;
  pelog_pkg::kind_e   kind;
  pelog_pkg::status_e status;
  logic               push, pop;

  // The register port never stalls.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      boot_q <= 16'd1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      boot_q <= cfg_data_i;
    end
  end

  assign busy = q_stat.full;
  assign push = start && !busy;

  pelog_front #(
    .PAYLOAD_BYTES(PAYLOAD_BYTES),
    .MAX_READ     (MAX_READ)
  ) u_front (
    .command_i       (command_i),
    .event_id_i      (event_id_i),
    .event_class_i   (event_class_i),
    .payload_i       (payload_i),
    .payload_length_i(payload_length_i),
    .read_limit_i    (read_limit_i),
    .time_now_i      (time_now_i),
    .boot_id_i       (boot_q),
    .op_o            (front_op)
  );

  // Hold classified words until the back end is free.
  pelog_fifo u_fifo (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push_i(push),
    .op_i  (front_op),
    .pop_i (pop),
    .op_o  (head_op),
    .stat_o(q_stat)
  );

  pelog_back #(
    .RING_DEPTH(RING_DEPTH)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .op_i              (head_op),
    .op_valid_i        (!q_stat.empty),
    .pop_o             (pop),
    .out_valid_o       (out_valid_o),
    .kind_o            (kind),
    .status_o          (status),
    .rec_timestamp_o   (rec_timestamp_o),
    .rec_event_id_o    (rec_event_id_o),
    .rec_class_o       (rec_class_o),
    .rec_subsystem_o   (rec_subsystem_o),
    .rec_payload_o     (rec_payload_o),
    .records_returned_o(records_returned_o),
    .last_o            (last_o)
  );

  assign kind_o   = kind;
  assign status_o = status;

  // A record word never closes a command.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind == pelog_pkg::KIND_REC) |-> !last_o)
    else $error("record word marked last");

  // Acknowledge and end marker words always close a command.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind != pelog_pkg::KIND_REC) |-> last_o)
    else $error("closing word not marked last");

  // Only an end marker reports a record count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && records_returned_o != 6'd0) |-> (kind == pelog_pkg::KIND_END))
    else $error("record count outside end marker");

  // A pop never happens from an empty queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_stat.empty)
    else $error("pop from empty queue");

endmodule

// ----- rtl/core/pelog_front.sv -----
// Front end: classify a command word, trim its payload and clip its read limit.
module pelog_front #(
  parameter int PAYLOAD_BYTES = 8,
  parameter int MAX_READ      = 63
) (
  input  logic [1:0]       command_i,
  input  logic [15:0]      event_id_i,
  input  logic [1:0]       event_class_i,
  input  logic [63:0]      payload_i,
  input  logic [7:0]       payload_length_i,
  input  logic [5:0]       read_limit_i,
  input  logic [31:0]      time_now_i,
  input  logic [15:0]      boot_id_i,
  output pelog_pkg::op_t   op_o
);

  localparam logic [7:0] PayBytes = 8'(PAYLOAD_BYTES);
  localparam logic [5:0] MaxRead  = 6'(MAX_READ);

  logic [7:0]  nbytes;
  logic [63:0] pay_m;
  logic [5:0]  limit_c;

  assign nbytes  = (payload_length_i > PayBytes) ? PayBytes : payload_length_i;
  assign limit_c = (read_limit_i > MaxRead) ? MaxRead : read_limit_i;

  // Zero every byte at or beyond the clipped length.
  always_comb begin
    for (int b = 0; b < 8; b++) begin
      pay_m[b*8 +: 8] = (8'(b) < nbytes) ? payload_i[b*8 +: 8] : 8'd0;
    end
  end

  always_comb begin
    op_o.cmd     = pelog_pkg::cmd_e'(command_i);
    op_o.id      = event_id_i;
    op_o.cls     = event_class_i;
    op_o.payload = pay_m;
    op_o.limit   = limit_c;
    op_o.now     = time_now_i;
    // Init logs the boot id as an info record with no payload.
    if (op_o.cmd == pelog_pkg::CMD_INIT) begin
      op_o.id      = boot_id_i;
      op_o.cls     = pelog_pkg::CLS_INFO;
      op_o.payload = 64'd0;
    end
  end

endmodule

// ----- rtl/core/pelog_fifo.sv -----
// Two-entry queue of classified command words between front and back.
module pelog_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  pelog_pkg::op_t     op_i,
  input  logic               pop_i,
  output pelog_pkg::op_t     op_o,
  output pelog_pkg::q_stat_t stat_o
);

  pelog_pkg::op_t ent_q [2];
  logic           wp_q, wp_d, rp_q, rp_d;
  logic [1:0]     cnt_q, cnt_d;

  assign stat_o.empty = (cnt_q == 2'd0);
  assign stat_o.full  = (cnt_q == 2'd2);
  assign op_o         = ent_q[rp_q];

  always_comb begin
    wp_d  = push_i ? ~wp_q : wp_q;
    rp_d  = pop_i ? ~rp_q : rp_q;
    cnt_d = cnt_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wp_q] <= op_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// ----- rtl/core/pelog_back.sv -----
// Back end: ring memory and the sequencer that carries out commands.
module pelog_back #(
  parameter int RING_DEPTH = 256
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  pelog_pkg::op_t       op_i,
  input  logic                 op_valid_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  output pelog_pkg::kind_e     kind_o,
  output pelog_pkg::status_e   status_o,
  output logic [31:0]          rec_timestamp_o,
  output logic [15:0]          rec_event_id_o,
  output logic [1:0]           rec_class_o,
  output logic [7:0]           rec_subsystem_o,
  output logic [63:0]          rec_payload_o,
  output logic [5:0]           records_returned_o,
  output logic                 last_o
);

  localparam int AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam logic [AW-1:0] LastIdx = AW'(RING_DEPTH - 1);
  localparam logic [AW:0]   Full    = (AW+1)'(RING_DEPTH);

  pelog_pkg::state_e state_q, state_d;
  pelog_pkg::op_t    cur_q, cur_d;
  pelog_pkg::slot_t  mem_q [RING_DEPTH];
  pelog_pkg::slot_t  rdata_q, wr_slot;
  logic [AW-1:0] wp_q, wp_d, idx_q, idx_d, wr_addr, rd_addr;
  logic [AW:0]   fill_q, fill_d, left_q, left_d;
  logic [5:0]    cnt_q, cnt_d;
  logic          started_q, started_d, wr_en, hit, rd_done, in_fill;

  logic                 ov_d, ov_q, last_d, last_q;
  pelog_pkg::kind_e     kind_d, kind_q;
  pelog_pkg::status_e   stat_d, stat_q;
  logic [31:0]          ts_d, ts_q;
  logic [15:0]          id_d, id_q;
  logic [1:0]           cls_d, cls_q;
  logic [63:0]          pay_d, pay_q;
  logic [5:0]           nret_d, nret_q;

  function automatic logic [AW-1:0] dec_idx(input logic [AW-1:0] i);
    return (i == '0) ? LastIdx : i - AW'(1);
  endfunction

  function automatic logic [AW-1:0] inc_idx(input logic [AW-1:0] i);
    return (i == LastIdx) ? '0 : i + AW'(1);
  endfunction

  assign pop_o   = (state_q == pelog_pkg::S_IDLE) && op_valid_i;
  assign rd_addr = (state_q == pelog_pkg::S_IDLE) ? wp_q : idx_q;
  assign hit     = rdata_q.vld;
  // Slots below the fill count are exactly the ones written since the last init.
  assign in_fill = ({1'b0, idx_q} < fill_q);
  assign rd_done = (left_q == (AW+1)'(1)) || (hit && (cnt_q + 6'd1 == cur_q.limit));

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pelog_pkg::S_IDLE: begin
        if (op_valid_i) begin
          unique case (op_i.cmd)
            pelog_pkg::CMD_LOG: begin
              if (started_q && op_i.id != 16'd0 && fill_q == Full) begin
                state_d = pelog_pkg::S_LOG_CHK;
              end
            end
            pelog_pkg::CMD_READ: begin
              if (started_q && op_i.limit != 6'd0 && fill_q != '0) begin
                state_d = pelog_pkg::S_RD_ISSUE;
              end
            end
            pelog_pkg::CMD_CLEAR: state_d = pelog_pkg::S_CLR_ISSUE;
            default: state_d = pelog_pkg::S_IDLE;
          endcase
        end
      end
      pelog_pkg::S_LOG_CHK:   state_d = pelog_pkg::S_IDLE;
      pelog_pkg::S_RD_ISSUE:  state_d = pelog_pkg::S_RD_CHECK;
      pelog_pkg::S_RD_CHECK:  state_d = rd_done ? pelog_pkg::S_RD_END : pelog_pkg::S_RD_ISSUE;
      pelog_pkg::S_RD_END:    state_d = pelog_pkg::S_IDLE;
      pelog_pkg::S_CLR_ISSUE: state_d = pelog_pkg::S_CLR_CHECK;
      pelog_pkg::S_CLR_CHECK: begin
        state_d = (idx_q == LastIdx) ? pelog_pkg::S_IDLE : pelog_pkg::S_CLR_ISSUE;
      end
      default: state_d = pelog_pkg::S_IDLE;
    endcase
  end

  // Datapath and results.
  always_comb begin
    cur_d     = cur_q;
    wp_d      = wp_q;
    fill_d    = fill_q;
    idx_d     = idx_q;
    left_d    = left_q;
    cnt_d     = cnt_q;
    started_d = started_q;
    wr_en     = 1'b0;
    wr_addr   = wp_q;
    wr_slot   = '{vld: 1'b1, cls: cur_q.cls, id: cur_q.id, ts: cur_q.now,
                  payload: cur_q.payload};
    ov_d      = 1'b0;
    kind_d    = pelog_pkg::KIND_ACK;
    stat_d    = pelog_pkg::STAT_DONE;
    ts_d      = 32'd0;
    id_d      = 16'd0;
    cls_d     = 2'd0;
    pay_d     = 64'd0;
    nret_d    = 6'd0;
    last_d    = 1'b0;
    unique case (state_q)
      pelog_pkg::S_IDLE: begin
        if (op_valid_i) begin
          cur_d   = op_i;
          wr_slot = '{vld: 1'b1, cls: op_i.cls, id: op_i.id, ts: op_i.now,
                      payload: op_i.payload};
          unique case (op_i.cmd)
            pelog_pkg::CMD_INIT: begin
              started_d = 1'b1;
              wp_d      = '0;
              fill_d    = '0;
              if (op_i.id != 16'd0) begin
                wr_en   = 1'b1;
                wr_addr = '0;
                wp_d    = inc_idx('0);
                fill_d  = (AW+1)'(1);
              end
              ov_d   = 1'b1;
              last_d = 1'b1;
            end
            pelog_pkg::CMD_LOG: begin
              if (!started_q || op_i.id == 16'd0) begin
                ov_d   = 1'b1;
                last_d = 1'b1;
                stat_d = pelog_pkg::STAT_IGNORED;
              end else if (fill_q != Full) begin
                wr_en  = 1'b1;
                wp_d   = inc_idx(wp_q);
                fill_d = fill_q + (AW+1)'(1);
                ov_d   = 1'b1;
                last_d = 1'b1;
              end
            end
            pelog_pkg::CMD_READ: begin
              if (!started_q || op_i.limit == 6'd0 || fill_q == '0) begin
                ov_d   = 1'b1;
                last_d = 1'b1;
                kind_d = pelog_pkg::KIND_END;
                stat_d = started_q ? pelog_pkg::STAT_DONE : pelog_pkg::STAT_IGNORED;
              end else begin
                idx_d  = dec_idx(wp_q);
                left_d = fill_q;
                cnt_d  = 6'd0;
              end
            end
            pelog_pkg::CMD_CLEAR: idx_d = '0;
            default: ;
          endcase
        end
      end
      pelog_pkg::S_LOG_CHK: begin
        ov_d   = 1'b1;
        last_d = 1'b1;
        // Drop the new word when the oldest slot holds a live critical record.
        if (rdata_q.vld && rdata_q.cls == pelog_pkg::CLS_CRITICAL) begin
          stat_d = pelog_pkg::STAT_DROPPED;
        end else begin
          wr_en = 1'b1;
          wp_d  = inc_idx(wp_q);
        end
      end
      pelog_pkg::S_RD_ISSUE: ;
      pelog_pkg::S_RD_CHECK: begin
        if (hit) begin
          ov_d   = 1'b1;
          kind_d = pelog_pkg::KIND_REC;
          ts_d   = rdata_q.ts;
          id_d   = rdata_q.id;
          cls_d  = rdata_q.cls;
          pay_d  = rdata_q.payload;
          cnt_d  = cnt_q + 6'd1;
        end
        left_d = left_q - (AW+1)'(1);
        idx_d  = dec_idx(idx_q);
      end
      pelog_pkg::S_RD_END: begin
        ov_d   = 1'b1;
        last_d = 1'b1;
        kind_d = pelog_pkg::KIND_END;
        nret_d = cnt_q;
      end
      pelog_pkg::S_CLR_ISSUE: ;
      pelog_pkg::S_CLR_CHECK: begin
        // Drop the valid flag of a live info record written since init.
        if (in_fill && rdata_q.vld && rdata_q.cls == pelog_pkg::CLS_INFO) begin
          wr_en       = 1'b1;
          wr_addr     = idx_q;
          wr_slot     = rdata_q;
          wr_slot.vld = 1'b0;
        end
        idx_d = inc_idx(idx_q);
        if (idx_q == LastIdx) begin
          ov_d   = 1'b1;
          last_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_slot;
    end
    rdata_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    idx_q  <= idx_d;
    left_q <= left_d;
    cnt_q  <= cnt_d;
    kind_q <= kind_d;
    stat_q <= stat_d;
    ts_q   <= ts_d;
    id_q   <= id_d;
    cls_q  <= cls_d;
    pay_q  <= pay_d;
    nret_q <= nret_d;
    last_q <= last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= pelog_pkg::S_IDLE;
      wp_q      <= '0;
      fill_q    <= '0;
      started_q <= 1'b0;
      ov_q      <= 1'b0;
    end else begin
      state_q   <= state_d;
      wp_q      <= wp_d;
      fill_q    <= fill_d;
      started_q <= started_d;
      ov_q      <= ov_d;
    end
  end

  assign out_valid_o        = ov_q;
  assign kind_o             = kind_q;
  assign status_o           = stat_q;
  assign rec_timestamp_o    = ts_q;
  assign rec_event_id_o     = id_q;
  assign rec_class_o        = cls_q;
  assign rec_subsystem_o    = id_q[15:8];
  assign rec_payload_o      = pay_q;
  assign records_returned_o = nret_q;
  assign last_o             = last_q;

endmodule

// ----- sim/tb_protected_event_ring_log_core.sv -----
// Testbench for protected_event_ring_log_core: self-checking, scoreboard predicts every word.
module tb_protected_event_ring_log_core;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH     = 256;
  localparam int PAY_BYTES = 8;
  localparam int READ_MAX  = 63;
  localparam int MAX_SHOWN = 10;

  // One command word as driven on the input ports.
  typedef struct {
    pelog_pkg::cmd_e cmd;
    logic [15:0]     id;
    logic [1:0]      cls;
    logic [63:0]     payload;
    logic [7:0]      len;
    logic [5:0]      limit;
    logic [31:0]     now;
  } cmd_word_t;

  // One result word as seen on the output ports.
  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  status;
    logic [31:0] ts;
    logic [15:0] id;
    logic [1:0]  cls;
    logic [7:0]  sub;
    logic [63:0] payload;
    logic [5:0]  count;
    logic        last;
  } result_word_t;

  // Scoreboard: keeps a shadow of the ring and the queue of expected result words.
  class ring_log_scoreboard;
    bit          slot_vld [DEPTH];
    logic [1:0]  slot_cls [DEPTH];
    logic [15:0] slot_id  [DEPTH];
    logic [31:0] slot_ts  [DEPTH];
    logic [63:0] slot_pay [DEPTH];
    int          wr_pos;
    int          fill;
    bit          started;
    logic [15:0] boot_id;
    result_word_t pending_results[$];
    int          errors;

    function new();
      wipe_ring();
      started = 0;
      boot_id = 16'd1;
      errors  = 0;
    endfunction

    function void wipe_ring();
      for (int i = 0; i < DEPTH; i++) begin
        slot_vld[i] = 0;
        slot_cls[i] = '0;
        slot_id[i]  = '0;
      end
      wr_pos = 0;
      fill   = 0;
    endfunction

    function void set_boot_id(logic [15:0] v);
      boot_id = v;
    endfunction

    // Append one record; return the status the block reports.
    function pelog_pkg::status_e append(logic [15:0] id, logic [1:0] cls, logic [63:0] pay,
                                        logic [7:0] len, logic [31:0] now);
      int n;
      logic [63:0] mask;
      if (!started || id == 16'd0) return pelog_pkg::STAT_IGNORED;
      if (fill >= DEPTH && slot_vld[wr_pos] && slot_cls[wr_pos] == pelog_pkg::CLS_CRITICAL)
        return pelog_pkg::STAT_DROPPED;
      n = (len > PAY_BYTES) ? PAY_BYTES : len;
      mask = (n >= 8) ? '1 : ((64'd1 << (8 * n)) - 64'd1);
      slot_vld[wr_pos] = 1;
      slot_cls[wr_pos] = cls;
      slot_id[wr_pos]  = id;
      slot_ts[wr_pos]  = now;
      slot_pay[wr_pos] = pay & mask;
      wr_pos = (wr_pos + 1) % DEPTH;
      if (fill < DEPTH) fill++;
      return pelog_pkg::STAT_DONE;
    endfunction

    function void push(pelog_pkg::kind_e k, pelog_pkg::status_e s, int slot, bit has_rec,
                       int cnt, bit lst);
      result_word_t r;
      r = '0;
      r.kind   = k;
      r.status = s;
      if (has_rec) begin
        r.ts      = slot_ts[slot];
        r.id      = slot_id[slot];
        r.cls     = slot_cls[slot];
        r.sub     = slot_id[slot][15:8];
        r.payload = slot_pay[slot];
      end
      r.count = cnt[5:0];
      r.last  = lst;
      pending_results.push_back(r);
    endfunction

    // Note an accepted command word and queue the words it will produce.
    function void note_command(cmd_word_t w);
      pelog_pkg::status_e st;
      int lim, n, k, idx;
      case (w.cmd)
        pelog_pkg::CMD_INIT: begin
          wipe_ring();
          started = 1;
          void'(append(boot_id, pelog_pkg::CLS_INFO, '0, 8'd0, w.now));
          push(pelog_pkg::KIND_ACK, pelog_pkg::STAT_DONE, 0, 0, 0, 1);
        end
        pelog_pkg::CMD_LOG: begin
          st = append(w.id, w.cls, w.payload, w.len, w.now);
          push(pelog_pkg::KIND_ACK, st, 0, 0, 0, 1);
        end
        pelog_pkg::CMD_READ: begin
          if (!started) begin
            push(pelog_pkg::KIND_END, pelog_pkg::STAT_IGNORED, 0, 0, 0, 1);
          end else begin
            lim = (w.limit > READ_MAX) ? READ_MAX : w.limit;
            n   = fill;
            k   = 0;
            idx = (wr_pos + DEPTH - 1) % DEPTH;
            for (int i = 0; i < n && k < lim; i++) begin
              if (slot_vld[idx]) begin
                push(pelog_pkg::KIND_REC, pelog_pkg::STAT_DONE, idx, 1, 0, 0);
                k++;
              end
              idx = (idx + DEPTH - 1) % DEPTH;
            end
            push(pelog_pkg::KIND_END, pelog_pkg::STAT_DONE, 0, 0, k, 1);
          end
        end
        default: begin
          // Clear-info drops info records only; fill count stays.
          for (int i = 0; i < DEPTH; i++)
            if (slot_vld[i] && slot_cls[i] == pelog_pkg::CLS_INFO) begin
              slot_vld[i] = 0;
              slot_cls[i] = '0;
              slot_id[i]  = '0;
            end
          push(pelog_pkg::KIND_ACK, pelog_pkg::STAT_DONE, 0, 0, 0, 1);
        end
      endcase
    endfunction

    // Compare one result word with the oldest expectation.
    function void check_result(result_word_t got);
      result_word_t want;
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= MAX_SHOWN) $display("unexpected result word: %p", got);
        return;
      end
      want = pending_results.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= MAX_SHOWN)
          $display("mismatch: expected %p, actual %p", want, got);
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [1:0]  command_i;
  logic [15:0] event_id_i;
  logic [1:0]  event_class_i;
  logic [63:0] payload_i;
  logic [7:0]  payload_length_i;
  logic [5:0]  read_limit_i;
  logic [31:0] time_now_i;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i;
  logic        out_valid_o;
  logic [1:0]  kind_o;
  logic [1:0]  status_o;
  logic [31:0] rec_timestamp_o;
  logic [15:0] rec_event_id_o;
  logic [1:0]  rec_class_o;
  logic [7:0]  rec_subsystem_o;
  logic [63:0] rec_payload_o;
  logic [5:0]  records_returned_o;
  logic        last_o;

  ring_log_scoreboard sb;
  bit no_gaps;

  protected_event_ring_log_core u_top (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start              (start),
    .busy               (busy),
    .command_i          (command_i),
    .event_id_i         (event_id_i),
    .event_class_i      (event_class_i),
    .payload_i          (payload_i),
    .payload_length_i   (payload_length_i),
    .read_limit_i       (read_limit_i),
    .time_now_i         (time_now_i),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_data_i         (cfg_data_i),
    .out_valid_o        (out_valid_o),
    .kind_o             (kind_o),
    .status_o           (status_o),
    .rec_timestamp_o    (rec_timestamp_o),
    .rec_event_id_o     (rec_event_id_o),
    .rec_class_o        (rec_class_o),
    .rec_subsystem_o    (rec_subsystem_o),
    .rec_payload_o      (rec_payload_o),
    .records_returned_o (records_returned_o),
    .last_o             (last_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Sample result words at the edge that ends their cycle.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o)
      sb.check_result({kind_o, status_o, rec_timestamp_o, rec_event_id_o, rec_class_o,
                       rec_subsystem_o, rec_payload_o, records_returned_o, last_o});
  end

  // Drive one command word; hold start between back-to-back words.
  task automatic send_word(cmd_word_t w);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start            <= 1'b1;
    command_i        <= w.cmd;
    event_id_i       <= w.id;
    event_class_i    <= w.cls;
    payload_i        <= w.payload;
    payload_length_i <= w.len;
    read_limit_i     <= w.limit;
    time_now_i       <= w.now;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    sb.note_command(w);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Write the boot identifier with the block idle; allow a clear sweep to finish.
  task automatic write_boot_id(logic [15:0] v);
    drain();
    repeat (20) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    sb.set_boot_id(v);
  endtask

  function automatic cmd_word_t mk(pelog_pkg::cmd_e c, logic [15:0] id = 16'h0101,
                                   logic [1:0] cls = pelog_pkg::CLS_INFO,
                                   logic [63:0] pay = '1,
                                   logic [7:0] len = 8'd8, logic [5:0] lim = 6'd63,
                                   logic [31:0] now = 32'h1234_5678);
    cmd_word_t w;
    w.cmd = c; w.id = id; w.cls = cls; w.payload = pay;
    w.len = len; w.limit = lim; w.now = now;
    return w;
  endfunction

  // Random command word; log_pct sets how log-heavy the mix is.
  function automatic cmd_word_t rand_word(int log_pct);
    cmd_word_t w;
    int r;
    r = $urandom_range(0, 99);
    if (r < log_pct) w.cmd = pelog_pkg::CMD_LOG;
    else if (r < log_pct + (100 - log_pct) * 6 / 10) w.cmd = pelog_pkg::CMD_READ;
    else if (r < 99) w.cmd = pelog_pkg::CMD_CLEAR;
    else w.cmd = pelog_pkg::CMD_INIT;
    w.id      = ($urandom_range(0, 19) == 0) ? 16'd0 : 16'($urandom);
    w.cls     = ($urandom_range(0, 24) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
    w.payload = {$urandom, $urandom};
    w.len     = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 8));
    w.limit   = 6'($urandom);
    w.now     = $urandom;
    return w;
  endfunction

  initial begin
    sb = new();
    no_gaps          = 0;
    rst_ni           = 1'b0;
    start            = 1'b0;
    command_i        = pelog_pkg::CMD_INIT;
    event_id_i       = '0;
    event_class_i    = '0;
    payload_i        = '0;
    payload_length_i = '0;
    read_limit_i     = '0;
    time_now_i       = '0;
    cfg_valid_i      = 1'b0;
    cfg_data_i       = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reads and logs before init are ignored, then the edges of each field.
    send_word(mk(pelog_pkg::CMD_READ));
    send_word(mk(pelog_pkg::CMD_LOG));
    send_word(mk(pelog_pkg::CMD_CLEAR));
    send_word(mk(pelog_pkg::CMD_INIT, .now(32'd0)));
    send_word(mk(pelog_pkg::CMD_LOG, .id(16'hFFFF), .cls(pelog_pkg::CLS_CRITICAL),
                 .len(8'd255), .now('1)));
    send_word(mk(pelog_pkg::CMD_LOG, .id(16'h0001), .cls(2'd1), .len(8'd0)));
    send_word(mk(pelog_pkg::CMD_LOG, .id(16'h8000), .cls(2'd3), .len(8'd3)));
    send_word(mk(pelog_pkg::CMD_LOG, .id(16'h0000)));
    send_word(mk(pelog_pkg::CMD_LOG, .id(16'h7F80), .cls(pelog_pkg::CLS_INFO), .len(8'd7),
                 .pay(64'h0)));
    send_word(mk(pelog_pkg::CMD_LOG, .id(16'h00FF), .cls(pelog_pkg::CLS_INFO), .len(8'd9)));
    send_word(mk(pelog_pkg::CMD_READ, .lim(6'd0)));
    send_word(mk(pelog_pkg::CMD_READ, .lim(6'd2)));
    send_word(mk(pelog_pkg::CMD_READ, .lim(6'd63)));
    send_word(mk(pelog_pkg::CMD_CLEAR));
    send_word(mk(pelog_pkg::CMD_READ));
    send_word(mk(pelog_pkg::CMD_INIT, .now(32'hFFFF_FFFF)));
    send_word(mk(pelog_pkg::CMD_READ));

    // Boot id at its top value, then zero: init with no boot record.
    write_boot_id(16'hFFFF);
    send_word(mk(pelog_pkg::CMD_INIT));
    send_word(mk(pelog_pkg::CMD_READ));
    write_boot_id(16'h0000);
    send_word(mk(pelog_pkg::CMD_INIT));
    send_word(mk(pelog_pkg::CMD_READ));
    send_word(mk(pelog_pkg::CMD_LOG, .id(16'h1234), .cls(pelog_pkg::CLS_CRITICAL)));
    send_word(mk(pelog_pkg::CMD_READ));

    // Fill the ring past full so protected critical records drop new events.
    write_boot_id(16'($urandom_range(1, 65535)));
    send_word(mk(pelog_pkg::CMD_INIT));
    for (int i = 0; i < 300; i++) begin
      no_gaps = (i >= 100 && i < 160);
      if (i == 200) drain();
      send_word(rand_word(92));
    end
    no_gaps = 0;

    // Mixed traffic after a fresh init with the boot id back at its low end.
    write_boot_id(16'd1);
    send_word(mk(pelog_pkg::CMD_INIT));
    for (int i = 0; i < 130; i++) send_word(rand_word(60));

    drain();
    repeat (600) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Hang guard: far beyond the slowest legal run.
  initial begin
    #50ms;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
